### rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page run allocator: request
// codes, response status codes and the geometry of one page-map word.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // Pages held in one word of the page map.
  localparam int WORD_W = 32;
  localparam int OFF_W  = $clog2(WORD_W);

  // Widths of the request and response fields.
  localparam int OP_W     = 1;
  localparam int CNT_W    = 11;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;

  // Request operations.
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADARG  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DOUBLE  = 2'd3;

endpackage

### rtl/core/first_fit_page_run_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_unit
// First-fit allocator of contiguous page runs over a used-bit page map.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_* channel (valid/ready). An allocate
// request carries a page count; the block returns the lowest start page of a
// free run of that length and marks the run used. A free request carries a
// start page and a count and clears those pages, flagging a double free if
// any of them was already free. Every request yields exactly one response on
// the out_* channel (valid/ready) with a status and the granted page.
// The page map is held in a RAM of 32-page words. Each word is handled by
// a read state and then an evaluate (or modify-and-write) state on the RAM port.
// An allocate scans words up to the hit (or all words), then marks the words
// the run spans; a free clears the words its run spans. Rejected requests
// and frees of zero pages are answered in the cycle after acceptance.
// After reset a clearing pass writes zero to every map word, one word per
// cycle over ceil(NUM_PAGES / 32) words, 32 at the default size; no request
// is taken during it. One request is in flight at a time: ready stays low
// while a request is worked on and while a response waits for the receiver,
// so a stalled receiver holds back the next request.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_unit #(
  parameter int NUM_PAGES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ffpa_pkg::OP_W-1:0]     op_i,
  input  logic [ffpa_pkg::CNT_W-1:0]    page_count_i,
  input  logic [ffpa_pkg::PAGE_W-1:0]   start_page_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffpa_pkg::STATUS_W-1:0] status_o,
  output logic [ffpa_pkg::PAGE_W-1:0]   granted_page_o
);

  localparam int WORD_W = ffpa_pkg::WORD_W;
  localparam int OFF_W  = ffpa_pkg::OFF_W;
  localparam int CNT_W  = ffpa_pkg::CNT_W;
  localparam int RUN_W  = CNT_W + 1;

  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = WA_W + OFF_W;
  localparam int CALC_W    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  localparam logic [WA_W-1:0]   LAST_WORD   = WA_W'(NUM_WORDS - 1);
  // Pages past the region end in the last word count as used during a scan.
  localparam logic [WORD_W-1:0] LAST_MASK   =
      {WORD_W{1'b1}} >> (WORD_W * NUM_WORDS - NUM_PAGES);
  localparam logic [CALC_W-1:0] NUM_PAGES_C = CALC_W'(NUM_PAGES);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN_RD = 3'd2;
  localparam logic [2:0] S_SCAN_EV = 3'd3;
  localparam logic [2:0] S_MARK_RD = 3'd4;
  localparam logic [2:0] S_MARK_WR = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [WA_W-1:0]               wa_q, wa_d;
  logic [CNT_W-1:0]              run_q, run_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [ffpa_pkg::OP_W-1:0]     op_q, op_d;
  logic [IDX_W-1:0]              lo_q, lo_d;
  logic [IDX_W-1:0]              hi_q, hi_d;
  logic                          twice_q, twice_d;
  logic [ffpa_pkg::PAGE_W-1:0]   grant_q, grant_d;
  logic                          out_valid_q, out_valid_d;
  logic [ffpa_pkg::STATUS_W-1:0] status_q, status_d;
  logic [ffpa_pkg::PAGE_W-1:0]   granted_q, granted_d;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  ffpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_q),
    .wdata_i (ram_wdata),
    .raddr_i (wa_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Run finder for one word. For each bit position the length of the free run
  // ending there is found on its own: the run carried in from earlier words
  // plus the bits so far, unless a used bit lies inside the word, in which
  // case the run starts after the last such bit. The first position whose
  // run reaches the count is the end of the first fit.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] free_w;
  logic [RUN_W-1:0]  run_len [WORD_W];
  logic [WORD_W-1:0] hit_vec;
  logic              hit_any;
  logic [OFF_W-1:0]  hit_pos;

  always_comb begin
    free_w = ~ram_rdata & ((wa_q == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
    for (int j = 0; j < WORD_W; j++) begin
      run_len[j] = RUN_W'({1'b0, run_q}) + RUN_W'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (!free_w[k]) begin
          run_len[j] = RUN_W'(j - k);
        end
      end
      hit_vec[j] = (run_len[j] >= {1'b0, cnt_q});
    end
    hit_any = |hit_vec;
    hit_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_pos = OFF_W'(j);
      end
    end
  end

  // Start of the run that ends at the hit position.
  logic [IDX_W-1:0]  hit_idx;
  logic [CALC_W-1:0] fit_start;

  assign hit_idx   = {wa_q, hit_pos};
  assign fit_start = CALC_W'(hit_idx) + CALC_W'(1) - CALC_W'(cnt_q);

  // --------------------------------------------------------------------------
  // Mask of the pages of the current word that lie inside [lo, hi].
  // --------------------------------------------------------------------------
  logic [OFF_W-1:0]  lo_off, hi_off;
  logic [WORD_W-1:0] run_mask;
  logic              last_mark_word;

  always_comb begin
    lo_off = (wa_q == lo_q[IDX_W-1:OFF_W]) ? lo_q[OFF_W-1:0] : '0;
    hi_off = (wa_q == hi_q[IDX_W-1:OFF_W]) ? hi_q[OFF_W-1:0] : OFF_W'(WORD_W - 1);
    run_mask = ({WORD_W{1'b1}} << lo_off) &
               ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi_off));
  end

  assign last_mark_word = (wa_q == hi_q[IDX_W-1:OFF_W]);

  // Request checks.
  logic [CALC_W-1:0] req_cnt, req_start, req_end_excl;
  logic              alloc_bad, free_bad;

  assign req_cnt      = CALC_W'(page_count_i);
  assign req_start    = CALC_W'(start_page_i);
  assign req_end_excl = req_start + req_cnt;
  assign alloc_bad    = (page_count_i == '0) || (req_cnt > NUM_PAGES_C);
  assign free_bad     = (req_start >= NUM_PAGES_C) || (req_end_excl > NUM_PAGES_C);

  logic in_fire;
  logic [CALC_W-1:0] free_last;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign free_last  = req_end_excl - CALC_W'(1);

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    wa_d        = wa_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    twice_d     = twice_q;
    grant_d     = grant_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    granted_d   = granted_q;
    ram_we      = 1'b0;
    ram_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (wa_q == LAST_WORD) begin
          state_d = S_IDLE;
          wa_d    = '0;
        end else begin
          wa_d = wa_q + WA_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          op_d    = op_i;
          cnt_d   = page_count_i;
          twice_d = 1'b0;
          grant_d = '0;
          if (op_i == ffpa_pkg::OP_ALLOC) begin
            if (alloc_bad) begin
              out_valid_d = 1'b1;
              status_d    = ffpa_pkg::STAT_BADARG;
              granted_d   = '0;
            end else begin
              wa_d    = '0;
              run_d   = '0;
              state_d = S_SCAN_RD;
            end
          end else begin
            if (free_bad) begin
              out_valid_d = 1'b1;
              status_d    = ffpa_pkg::STAT_BADARG;
              granted_d   = '0;
            end else if (page_count_i == '0) begin
              out_valid_d = 1'b1;
              status_d    = ffpa_pkg::STAT_OK;
              granted_d   = '0;
            end else begin
              lo_d    = req_start[IDX_W-1:0];
              hi_d    = free_last[IDX_W-1:0];
              wa_d    = req_start[IDX_W-1:OFF_W];
              state_d = S_MARK_RD;
            end
          end
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (hit_any) begin
          lo_d    = fit_start[IDX_W-1:0];
          hi_d    = hit_idx;
          grant_d = fit_start[ffpa_pkg::PAGE_W-1:0];
          wa_d    = fit_start[IDX_W-1:OFF_W];
          state_d = S_MARK_RD;
        end else if (wa_q == LAST_WORD) begin
          out_valid_d = 1'b1;
          status_d    = ffpa_pkg::STAT_NOSPACE;
          granted_d   = '0;
          wa_d        = '0;
          state_d     = S_IDLE;
        end else begin
          run_d   = run_len[WORD_W-1][CNT_W-1:0];
          wa_d    = wa_q + WA_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_MARK_RD: begin
        state_d = S_MARK_WR;
      end

      S_MARK_WR: begin
        ram_we = 1'b1;
        if (op_q == ffpa_pkg::OP_ALLOC) begin
          ram_wdata = ram_rdata | run_mask;
        end else begin
          ram_wdata = ram_rdata & ~run_mask;
          twice_d   = twice_q || ((~ram_rdata & run_mask) != '0);
        end
        if (last_mark_word) begin
          out_valid_d = 1'b1;
          status_d    = twice_d ? ffpa_pkg::STAT_DOUBLE : ffpa_pkg::STAT_OK;
          granted_d   = grant_q;
          wa_d        = '0;
          state_d     = S_IDLE;
        end else begin
          wa_d    = wa_q + WA_W'(1);
          state_d = S_MARK_RD;
        end
      end

      default: begin
        state_d = S_CLEAR;
        wa_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wa_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q     <= run_d;
    cnt_q     <= cnt_d;
    op_q      <= op_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    twice_q   <= twice_d;
    grant_q   <= grant_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_page_o = granted_q;

endmodule

### rtl/core/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the page run allocator, bound to its top level.
// ----------------------------------------------------------------------------
module ffpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ffpa_pkg::STATUS_W-1:0] status_o,
  input logic [ffpa_pkg::PAGE_W-1:0]   granted_page_o
);

  // A response that is not taken stays offered with the same content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
                                    && $stable(granted_page_o))
    else $error("response dropped or changed while stalled");

  // No new request is taken while a response is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while a response waits");

  // One request at a time: after an acceptance the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken back to back");

  // Only a successful allocate reports a nonzero page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ffpa_pkg::STAT_OK) |-> granted_page_o == '0)
    else $error("granted page set on a failed request");

endmodule

bind first_fit_page_run_allocator_unit ffpa_checker u_ffpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .granted_page_o (granted_page_o)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_page_run_allocator_unit. A directed
// sequence covers rejected counts, full and empty regions, zero-length and
// out-of-range frees, double frees and first-fit reuse of a hole. A random
// sequence then mixes allocations, frees of granted runs and malformed
// requests. An in-bench page map predicts every response, and random
// back-pressure runs on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_PAGES      = 1024;
  localparam int          RANDOM_ITEMS   = 1080;
  localparam int          DIRECTED_ITEMS = 22;
  localparam int          TOTAL_ITEMS    = RANDOM_ITEMS + DIRECTED_ITEMS;
  // The longest request (full scan plus a run over every word) takes far less
  // than this margin, which also covers any stall the receiver can produce.
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int unsigned MAX_PRINTED    = 100;

  typedef struct {
    logic [ffpa_pkg::STATUS_W-1:0] status;
    logic [ffpa_pkg::PAGE_W-1:0]   granted;
  } response_t;

  // Page map model plus the queue of responses that the block still owes.
  class page_map_scoreboard #(int PAGES = 1024);
    bit          page_used [PAGES];
    response_t   expected_q [$];
    int unsigned errors;

    function new();
      foreach (page_used[i]) page_used[i] = 1'b0;
      errors = 0;
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    // First fit: lowest start of a free run of the requested length.
    function void fit_run(input int unsigned count, output response_t rsp);
      int unsigned run_len;
      int unsigned first;
      rsp.status  = ffpa_pkg::STAT_NOSPACE;
      rsp.granted = '0;
      run_len     = 0;
      if (count == 0 || count > PAGES) begin
        rsp.status = ffpa_pkg::STAT_BADARG;
        return;
      end
      for (int unsigned i = 0; i < PAGES; i++) begin
        if (page_used[i]) begin
          run_len = 0;
        end else begin
          run_len++;
          if (run_len == count) begin
            first = i + 1 - count;
            for (int unsigned k = first; k <= i; k++) page_used[k] = 1'b1;
            rsp.status  = ffpa_pkg::STAT_OK;
            rsp.granted = ffpa_pkg::PAGE_W'(first);
            return;
          end
        end
      end
    endfunction

    // The whole run is cleared even when some of its pages were already free.
    function void release_run(input int unsigned start, input int unsigned count,
                              output response_t rsp);
      bit twice;
      twice       = 1'b0;
      rsp.granted = '0;
      if (start >= PAGES || count > PAGES - start) begin
        rsp.status = ffpa_pkg::STAT_BADARG;
        return;
      end
      for (int unsigned k = start; k < start + count; k++) begin
        if (!page_used[k]) twice = 1'b1;
        page_used[k] = 1'b0;
      end
      rsp.status = twice ? ffpa_pkg::STAT_DOUBLE : ffpa_pkg::STAT_OK;
    endfunction

    function void note_request(input logic [ffpa_pkg::OP_W-1:0] op,
                               input int unsigned count,
                               input int unsigned start, output response_t rsp);
      if (op == ffpa_pkg::OP_ALLOC) fit_run(count, rsp);
      else release_run(start, count, rsp);
      expected_q.push_back(rsp);
    endfunction

    task check_response(input logic [ffpa_pkg::STATUS_W-1:0] status,
                        input logic [ffpa_pkg::PAGE_W-1:0] granted);
      response_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("response status %0d page %0d with no request pending",
                                  status, granted));
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (granted !== want.granted)
        report_mismatch($sformatf("granted page %0d, expected %0d", granted, want.granted));
    endtask
  endclass

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [ffpa_pkg::OP_W-1:0]     op_i           = ffpa_pkg::OP_ALLOC;
  logic [ffpa_pkg::CNT_W-1:0]    page_count_i   = '0;
  logic [ffpa_pkg::PAGE_W-1:0]   start_page_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [ffpa_pkg::STATUS_W-1:0] status_o;
  logic [ffpa_pkg::PAGE_W-1:0]   granted_page_o;

  page_map_scoreboard #(NUM_PAGES) sb;

  // Runs granted so far, as predicted; frees are mostly drawn from here.
  int unsigned live_start [$];
  int unsigned live_count [$];
  int unsigned requests_sent  = 0;
  int unsigned send_idle_pct  = 7;
  int unsigned recv_idle_pct  = 63;
  int unsigned idle_cycles    = 0;

  first_fit_page_run_allocator_unit #(
    .NUM_PAGES(NUM_PAGES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .page_count_i  (page_count_i),
    .start_page_i  (start_page_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .granted_page_o(granted_page_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sends one request and waits for its acceptance. The idle share of both
  // sides follows the run's thirds: slow receiver, then slow sender, then
  // no idling at all.
  task automatic issue_request(input logic [ffpa_pkg::OP_W-1:0] op,
                               input int unsigned count,
                               input int unsigned start);
    response_t rsp;
    case (requests_sent * 3 / TOTAL_ITEMS)
      0: begin
        send_idle_pct = 7;
        recv_idle_pct = 63;
      end
      1: begin
        send_idle_pct = 63;
        recv_idle_pct = 7;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    page_count_i <= ffpa_pkg::CNT_W'(count);
    start_page_i <= ffpa_pkg::PAGE_W'(start);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, count, start, rsp);
    if (op == ffpa_pkg::OP_ALLOC && rsp.status == ffpa_pkg::STAT_OK) begin
      live_start.push_back(rsp.granted);
      live_count.push_back(count);
    end
    requests_sent++;
  endtask

  // Mostly well-formed traffic: allocations of small runs, frees of granted
  // runs (some only in part), with malformed requests and full clears mixed in.
  task automatic random_request();
    int unsigned pick;
    int unsigned idx;
    int unsigned count;
    int unsigned start;
    pick  = $urandom_range(0, 99);
    start = $urandom_range(0, NUM_PAGES - 1);
    count = $urandom_range(1, 24);
    if ($urandom_range(0, 9) == 0) count = $urandom_range(25, 300);
    if ($urandom_range(0, 49) == 0) count = $urandom_range(301, NUM_PAGES);
    if (pick < 55 || (pick < 85 && live_start.size() == 0)) begin
      issue_request(ffpa_pkg::OP_ALLOC, count, start);
    end else if (pick < 85) begin
      idx   = $urandom_range(0, live_start.size() - 1);
      start = live_start[idx];
      count = live_count[idx];
      live_start.delete(idx);
      live_count.delete(idx);
      if ($urandom_range(0, 7) == 0) count = $urandom_range(0, count);
      issue_request(ffpa_pkg::OP_FREE, count, start);
    end else if (pick < 93) begin
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 64);
      issue_request(ffpa_pkg::OP_FREE, count, start);
    end else if (pick < 97) begin
      count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(NUM_PAGES + 1, 2047);
      issue_request(ffpa_pkg::OP_ALLOC, count, start);
    end else begin
      issue_request(ffpa_pkg::OP_FREE, NUM_PAGES, 0);
      live_start.delete();
      live_count.delete();
    end
  endtask

  // Response side: check what was accepted at this edge, then pick the next
  // ready level.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) sb.check_response(status_o, granted_page_o);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Ends a hung run: too many cycles without a handshake on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rejected allocation counts, then a one-page allocate; the start field is ignored on allocate.
    issue_request(ffpa_pkg::OP_ALLOC, 0, 0);
    issue_request(ffpa_pkg::OP_ALLOC, NUM_PAGES + 1, 0);
    issue_request(ffpa_pkg::OP_ALLOC, 2047, 1023);
    issue_request(ffpa_pkg::OP_ALLOC, 1, 1023);
    // One page in use, so the whole region no longer fits.
    issue_request(ffpa_pkg::OP_ALLOC, NUM_PAGES, 0);
    issue_request(ffpa_pkg::OP_FREE, 1, 0);
    issue_request(ffpa_pkg::OP_FREE, 1, 0);
    // Zero-length free at the last page, a run past the end, a free page, an oversized count.
    issue_request(ffpa_pkg::OP_FREE, 0, 1023);
    issue_request(ffpa_pkg::OP_FREE, 2, 1023);
    issue_request(ffpa_pkg::OP_FREE, 1, 1023);
    issue_request(ffpa_pkg::OP_FREE, 2047, 0);
    // Whole region in one run, then nothing left.
    issue_request(ffpa_pkg::OP_ALLOC, NUM_PAGES, 0);
    issue_request(ffpa_pkg::OP_ALLOC, 1, 0);
    issue_request(ffpa_pkg::OP_FREE, NUM_PAGES, 0);
    // Punch a hole and let first fit reuse it.
    issue_request(ffpa_pkg::OP_ALLOC, 3, 0);
    issue_request(ffpa_pkg::OP_ALLOC, 5, 0);
    issue_request(ffpa_pkg::OP_ALLOC, 2, 0);
    issue_request(ffpa_pkg::OP_FREE, 5, 3);
    issue_request(ffpa_pkg::OP_ALLOC, 4, 0);
    issue_request(ffpa_pkg::OP_ALLOC, 2, 0);
    issue_request(ffpa_pkg::OP_FREE, NUM_PAGES, 512);
    issue_request(ffpa_pkg::OP_FREE, NUM_PAGES, 0);
    live_start.delete();
    live_count.delete();

    repeat (RANDOM_ITEMS) random_request();
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
